// ----- sv/icdf_pkg.sv -----
// icdf_pkg: shared types and constants of the inverse cdf table sampler
// no dependencies; imported by the cell and the top level
package icdf_pkg;

  // item codes of the mode field
  localparam logic [1:0] MODE_WRITE       = 2'd0;
  localparam logic [1:0] MODE_DISCRETE    = 2'd1;
  localparam logic [1:0] MODE_CONTINUOUS  = 2'd2;
  localparam logic [1:0] MODE_INTERPOLATE = 2'd3;

  // fraction bits of the Q16.16 value format
  localparam int VALUE_FRAC = 16;

  // bin index width carried in the token, enough for the largest table
  localparam int BIN_W = 10;

  // query token that walks down the row of cells
  typedef struct packed {
    logic              active;
    logic              found;
    logic              need_next;
    logic              beyond;
    logic [BIN_W-1:0]  bin;
    logic [31:0]       word;
    logic [31:0]       prev;
    logic [31:0]       base;
    logic [31:0]       top;
    logic [31:0]       v0;
    logic [31:0]       v1;
  } icdf_token_t;

endpackage

// ----- sv/icdf_if.sv -----
// icdf_if: valid/ready channel interfaces for sample items and results
// depends on nothing; used by inverse_cdf_table_sampler
interface icdf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [31:0]        random_word;
  logic [6:0]         entry_index;
  logic signed [31:0] entry_value;
  logic [31:0]        entry_cumulative;

  modport source (output valid, mode, random_word, entry_index, entry_value,
                  entry_cumulative, input ready);
  modport sink (input valid, mode, random_word, entry_index, entry_value,
                entry_cumulative, output ready);
endinterface

interface icdf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic               no_hit;
  logic [5:0]         bin_found;

  modport source (output valid, sample_value, no_hit, bin_found, input ready);
  modport sink (input valid, sample_value, no_hit, bin_found, output ready);
endinterface

// ----- sv/icdf_cell.sv -----
// icdf_cell: one table bin (value and cumulative count) plus one token stage
// depends on icdf_pkg
module icdf_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CW-1:0]         n,
  input  logic                  wr_en,
  input  logic [CW-1:0]         wr_idx,
  input  logic [31:0]           wr_value,
  input  logic [31:0]           wr_cum,
  input  icdf_pkg::icdf_token_t tok_in,
  output icdf_pkg::icdf_token_t tok_out
);
  import icdf_pkg::*;

  localparam logic [CW-1:0] ID = CW'(IDX);

  logic [31:0]  value;
  logic [31:0]  cum;
  icdf_token_t  tok_next;

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == ID) begin
      value <= wr_value;
      cum   <= wr_cum;
    end
  end

  // bin test, or pick up the upper value for the bin just found
  always_comb begin
    tok_next      = tok_in;
    tok_next.prev = cum;
    if (tok_in.active && !tok_in.found && ID < n) begin
      if (cum > tok_in.word || ID + 1'b1 == n) begin
        tok_next.found     = 1'b1;
        tok_next.need_next = 1'b1;
        tok_next.beyond    = tok_in.word > cum;
        tok_next.bin       = BIN_W'(IDX);
        tok_next.v0        = value;
        tok_next.base      = tok_in.prev;
        tok_next.top       = cum;
      end
    end else if (tok_in.active && tok_in.need_next) begin
      tok_next.v1        = value;
      tok_next.need_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ----- sv/icdf_div.sv -----
// icdf_div: restoring divider for the interpolation weight, one bit a cycle
// no package needed; used by inverse_cdf_table_sampler
module icdf_div #(
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   num,
  input  logic [31:0]   den,
  output logic          done,
  output logic [QW-1:0] quot
);
  localparam int CNTW = $clog2(QW + 1);

  logic [32:0]   rem;
  logic [31:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic          busy;
  logic [32:0]   rem2;
  logic          fits;

  // one quotient bit per step, num < den holds at start
  assign rem2 = {rem[31:0], 1'b0};
  assign fits = rem2 >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(QW);
        rem  <= {1'b0, num};
        dvs  <= den;
      end else if (busy) begin
        rem  <= fits ? rem2 - {1'b0, dvs} : rem2;
        quot <= {quot[QW-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/inverse_cdf_table_sampler.sv -----
// inverse_cdf_table_sampler: top level, cell row, weight divider and output
// depends on icdf_pkg, icdf_if, icdf_cell, icdf_div
//
// Draws samples from a loaded table of bins by inverse transform. Mode 0
// items write one bin (value and cumulative count); index BINS writes only
// the upper end value. Sample items send a token down a row of BINS cells,
// one cell per cycle, which finds the first in-use bin whose cumulative
// count exceeds the random word, or else the last in-use bin. A discrete or
// continuous sample takes its result from the token leaving the row; an
// interpolated one adds a serial divider and a multiply and add stage (no
// divide when the weight is a half or one). One item is in flight at a time.
// The user must write bins_in_use through cfg_we/cfg_data only while idle;
// the block does not enforce this. Values above BINS saturate to BINS.
module inverse_cdf_table_sampler #(
  parameter int BINS          = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  icdf_in_if.sink    in_ch,
  icdf_out_if.source out_ch
);
  import icdf_pkg::*;

  localparam int CW = ($clog2(BINS + 1) > 7) ? $clog2(BINS + 1) : 7;
  localparam logic [CW-1:0] BINS_C = CW'(BINS);
  localparam int PW = 33 + FRACTION_BITS + 2;
  localparam logic [FRACTION_BITS:0] F_ONE  = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
  localparam logic [FRACTION_BITS:0] F_HALF = (FRACTION_BITS+1)'(1) << (FRACTION_BITS - 1);
  localparam logic signed [PW-1:0] P_HALF  = PW'(1) << (FRACTION_BITS - 1);
  localparam logic signed [PW-1:0] S_MAX   = PW'(32'sh7fffffff);
  localparam logic signed [PW-1:0] S_MIN   = -PW'(33'sh080000000);
  localparam logic [31:0] FRAC_MASK = (32'd1 << VALUE_FRAC) - 32'd1;
  localparam logic [31:0] INT_ONE   = 32'd1 << VALUE_FRAC;

  typedef enum logic [2:0] {
    S_IDLE, S_CHAIN, S_DIV, S_MUL, S_ADD, S_DONE
  } state_t;

  state_t                   state;
  logic [CW-1:0]            n;
  logic [CW-1:0]            cfg_ext;
  logic [31:0]              extra_value;
  logic [1:0]               cur_mode;
  icdf_token_t              chain [BINS+1];
  icdf_token_t              launch;
  logic                     in_xfer;
  logic                     wr_en;
  logic [CW-1:0]            wr_idx;
  icdf_token_t              tl;
  logic [31:0]              v1_sel;
  logic [31:0]              width_c;
  logic [31:0]              num_c;
  logic                     div_start;
  logic                     div_done;
  logic [FRACTION_BITS-1:0] div_q;
  logic [31:0]              v0;
  logic [31:0]              v1;
  logic [FRACTION_BITS:0]   f;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     diff;
  logic signed [PW-1:0]     sum;
  logic [31:0]              res_value;
  logic                     res_nohit;
  logic [5:0]               res_bin;
  logic [31:0]              trunc_c;

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign wr_en       = in_xfer && in_ch.mode == MODE_WRITE;
  assign wr_idx      = CW'(in_ch.entry_index);
  assign cfg_ext     = CW'(cfg_data);

  // bins_in_use register, saturated to the table size
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cfg_we) begin
      n <= (cfg_ext > BINS_C) ? BINS_C : cfg_ext;
    end
  end

  // upper end value that sits past the last cell
  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == BINS_C) begin
      extra_value <= in_ch.entry_value;
    end
  end

  // fresh token for a sample transfer
  always_comb begin
    launch        = '0;
    launch.active = in_xfer && in_ch.mode != MODE_WRITE;
    launch.word   = in_ch.random_word;
  end

  // token launch into the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].active <= 1'b0;
    end else begin
      chain[0] <= launch;
    end
  end

  // row of bin cells
  for (genvar i = 0; i < BINS; i++) begin : g_cell
    icdf_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .n        (n),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_value (in_ch.entry_value),
      .wr_cum   (in_ch.entry_cumulative),
      .tok_in   (chain[i]),
      .tok_out  (chain[i+1])
    );
  end

  // token leaving the row
  assign tl      = chain[BINS];
  assign v1_sel  = tl.need_next ? extra_value : tl.v1;
  assign width_c = tl.top - tl.base;
  assign num_c   = tl.word - tl.base;
  assign trunc_c = (tl.v0 & ~FRAC_MASK)
                   + ((tl.v0[31] && (tl.v0 & FRAC_MASK) != 32'd0) ? INT_ONE : 32'd0);
  assign div_start = (state == S_CHAIN) && tl.active && cur_mode == MODE_INTERPOLATE
                     && tl.found && !tl.beyond && width_c != 32'd0 && num_c < width_c;

  icdf_div #(.QW(FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_c),
    .den   (width_c),
    .done  (div_done),
    .quot  (div_q)
  );

  // blend arithmetic
  assign diff = PW'($signed(v1)) - PW'($signed(v0));
  assign sum  = PW'($signed(v0)) + ((prod + P_HALF) >>> FRACTION_BITS);

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      // result valid: set when the result is loaded, cleared on transfer
      if (state == S_DONE && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer && in_ch.mode != MODE_WRITE) begin
            cur_mode <= in_ch.mode;
            state    <= S_CHAIN;
          end
        end
        S_CHAIN: begin
          if (tl.active) begin
            v0 <= tl.v0;
            v1 <= v1_sel;
            if (cur_mode == MODE_DISCRETE) begin
              res_value <= tl.found ? trunc_c : 32'd0;
              res_nohit <= 1'b0;
              res_bin   <= tl.found ? tl.bin[5:0] : 6'd0;
              state     <= S_DONE;
            end else if (!tl.found || tl.beyond) begin
              res_value <= 32'd0;
              res_nohit <= 1'b1;
              res_bin   <= '0;
              state     <= S_DONE;
            end else begin
              res_nohit <= 1'b0;
              res_bin   <= tl.bin[5:0];
              if (cur_mode == MODE_CONTINUOUS) begin
                res_value <= tl.v0;
                state     <= S_DONE;
              end else if (width_c == 32'd0) begin
                f     <= F_HALF;
                state <= S_MUL;
              end else if (num_c >= width_c) begin
                f     <= F_ONE;
                state <= S_MUL;
              end else begin
                state <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            f     <= {1'b0, div_q};
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PW'(diff * $signed({1'b0, f}));
          state <= S_ADD;
        end
        S_ADD: begin
          if (sum > S_MAX) begin
            res_value <= S_MAX[31:0];
          end else if (sum < S_MIN) begin
            res_value <= S_MIN[31:0];
          end else begin
            res_value <= sum[31:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.sample_value <= res_value;
            out_ch.no_hit       <= res_nohit;
            out_ch.bin_found    <= res_bin;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/inverse_cdf_table_sampler_tb.sv -----
// inverse_cdf_table_sampler_tb: self-checking bench for the inverse cdf table sampler
// depends on icdf_pkg, icdf_if and the inverse_cdf_table_sampler rtl
`timescale 1ns / 1ps

module inverse_cdf_table_sampler_tb;
  import icdf_pkg::*;

  localparam int BINS          = 64;
  localparam int FRACTION_BITS = 16;
  localparam int DRAIN_CYCLES  = BINS + FRACTION_BITS + 24;
  localparam int IDLE_LIMIT    = 5000;
  localparam int LONG_HOLD     = 600;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 150;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] word;
    logic [6:0]  index;
    logic [31:0] value;
    logic [31:0] cumulative;
  } sample_item_t;

  typedef struct {
    logic [31:0] value;
    logic        no_hit;
    logic [5:0]  bin;
  } sample_result_t;

  // mirror of the table contents and the expected sample outputs
  class sample_scoreboard;
    logic [31:0]    value_tab[BINS+1];
    logic [31:0]    cum_tab[BINS];
    int unsigned    bins_loaded;
    sample_result_t pending_samples[$];
    int             failures;

    function new();
      bins_loaded = 0;
      failures    = 0;
      foreach (value_tab[i]) value_tab[i] = '0;
      foreach (cum_tab[i]) cum_tab[i] = '0;
    endfunction

    function void set_bins(logic [6:0] v);
      bins_loaded = (v > BINS) ? BINS : v;
    endfunction

    function int unsigned search_bin(logic [31:0] word);
      for (int unsigned i = 0; i < bins_loaded; i++)
        if (cum_tab[i] > word) return i;
      return bins_loaded - 1;
    endfunction

    // clear fraction toward zero
    function logic [31:0] to_integer(logic [31:0] u);
      logic [31:0] frac, r;
      frac = u & 32'h0000_ffff;
      r = u - frac;
      if (u[31] && frac != 0) r = r + 32'h0001_0000;
      return r;
    endfunction

    // linear blend toward the next bin value, rounded half up, saturated
    function logic [31:0] blend(int unsigned i, logic [31:0] word);
      logic [31:0] base, span;
      logic [63:0] num;
      longint      weight, v0, v1, acc;
      base = (i > 0) ? cum_tab[i-1] : 32'd0;
      span = cum_tab[i] - base;
      v0 = longint'($signed(value_tab[i]));
      v1 = longint'($signed(value_tab[i+1]));
      if (span == 0) begin
        weight = longint'(1) << (FRACTION_BITS - 1);
      end else begin
        num = {32'd0, word - base} << FRACTION_BITS;
        weight = longint'(num / {32'd0, span});
        if (weight > (longint'(1) << FRACTION_BITS)) weight = longint'(1) << FRACTION_BITS;
      end
      acc = (((v1 - v0) * weight + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS)
            + v0;
      if (acc > longint'(32'sh7fff_ffff)) acc = longint'(32'sh7fff_ffff);
      if (acc < -longint'(64'h8000_0000)) acc = -longint'(64'h8000_0000);
      return acc[31:0];
    endfunction

    // accepted input transfer: update tables or queue the expected sample
    function void note_input(sample_item_t it);
      sample_result_t r;
      int unsigned    i;
      if (it.mode == MODE_WRITE) begin
        if (it.index <= BINS) value_tab[it.index] = it.value;
        if (it.index < BINS) cum_tab[it.index] = it.cumulative;
        return;
      end
      r.value = '0; r.no_hit = 1'b0; r.bin = '0;
      if (it.mode == MODE_DISCRETE) begin
        if (bins_loaded > 0) begin
          i = search_bin(it.word);
          r.bin = i[5:0];
          r.value = to_integer(value_tab[i]);
        end
      end else if (bins_loaded == 0 || it.word > cum_tab[bins_loaded-1]) begin
        r.no_hit = 1'b1;
      end else begin
        i = search_bin(it.word);
        r.bin = i[5:0];
        r.value = (it.mode == MODE_CONTINUOUS) ? value_tab[i] : blend(i, it.word);
      end
      pending_samples.push_back(r);
    endfunction

    // accepted output transfer against the oldest expectation
    function void check_result(logic [31:0] value, logic no_hit, logic [5:0] bin);
      sample_result_t e;
      if (pending_samples.size() == 0) begin
        $error("unexpected result value=%h no_hit=%0d bin=%0d", value, no_hit, bin);
        failures++;
        return;
      end
      e = pending_samples.pop_front();
      if (value !== e.value) begin
        $error("sample_value expected %h actual %h", e.value, value);
        failures++;
      end
      if (no_hit !== e.no_hit) begin
        $error("no_hit expected %0d actual %0d", e.no_hit, no_hit);
        failures++;
      end
      if (bin !== e.bin) begin
        $error("bin_found expected %0d actual %0d", e.bin, bin);
        failures++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [6:0] cfg_data;

  icdf_in_if  in_ch();
  icdf_out_if out_ch();

  inverse_cdf_table_sampler #(.BINS(BINS), .FRACTION_BITS(FRACTION_BITS)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  sample_scoreboard sb = new();
  int  burst_left;
  bit  hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: stall pattern with changing density, plus one long hold-off
  int  ready_pct = 100;
  int  pattern_cnt = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.sample_value, out_ch.no_hit, out_ch.bin_found);
      pattern_cnt++;
      if (pattern_cnt >= 200) begin
        pattern_cnt = 0;
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 70;
          2: ready_pct = 30;
          default: ready_pct = 90;
        endcase
      end
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("inverse_cdf_table_sampler: mismatch");
      $finish;
    end
  end

  // offer one item and hold it until the transfer, then maybe open a gap
  task automatic send_item(sample_item_t it);
    int gap;
    in_ch.valid            <= 1'b1;
    in_ch.mode             <= it.mode;
    in_ch.random_word      <= it.word;
    in_ch.entry_index      <= it.index;
    in_ch.entry_value      <= it.value;
    in_ch.entry_cumulative <= it.cumulative;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_entry(logic [6:0] index, logic [31:0] value, logic [31:0] cum);
    sample_item_t it;
    it.mode = MODE_WRITE; it.word = $urandom(); it.index = index;
    it.value = value; it.cumulative = cum;
    send_item(it);
  endtask

  task automatic sample(logic [1:0] mode, logic [31:0] word);
    sample_item_t it;
    it.mode = mode; it.word = word; it.index = 7'($urandom());
    it.value = $urandom(); it.cumulative = $urandom();
    send_item(it);
  endtask

  // register write once the block has drained
  task automatic set_bins(logic [6:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_bins(v);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // full table load with sorted cumulative counts of a given shape
  task automatic load_table(int shape);
    logic [32:0] acc;
    logic [31:0] step;
    acc = 0;
    for (int i = 0; i <= BINS; i++) begin
      case (shape)
        0: step = $urandom_range(0, 32'h0400_0000);
        1: step = $urandom_range(0, 32'h0800_0000);
        default: step = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 32'h0010_0000);
      endcase
      if ($urandom_range(0, 7) == 0) step = 0;
      acc = acc + step;
      if (acc > 33'h0_ffff_ffff) acc = 33'h0_ffff_ffff;
      if (shape == 2 && i == BINS - 1) acc = 33'h0_ffff_ffff;
      write_entry(i[6:0], random_value(), (i == BINS) ? $urandom() : acc[31:0]);
    end
  endtask

  // sample word aimed at bin edges, the extremes or the table end, else random
  function automatic logic [31:0] pick_word();
    logic [31:0] c;
    if (sb.bins_loaded == 0) return $urandom();
    c = sb.cum_tab[$urandom_range(0, sb.bins_loaded - 1)];
    case ($urandom_range(0, 7))
      0: return c;
      1: return c - 1;
      2: return c + 1;
      3: return 32'd0;
      4: return 32'hffff_ffff;
      5: return sb.cum_tab[sb.bins_loaded-1] + $urandom_range(0, 2);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [6:0] bins_choice[PHASES] = '{7'd64, 7'd127, 7'd1, 7'd2, 7'd0, 7'd33,
                                        7'd64, 7'd100, 7'd63, 7'd64, 7'd17, 7'd64};
    int          pick;
    logic [31:0] word;
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_data               <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.mode             <= MODE_WRITE;
    in_ch.random_word      <= '0;
    in_ch.entry_index      <= '0;
    in_ch.entry_value      <= '0;
    in_ch.entry_cumulative <= '0;
    hold_req = 0;
    burst_left = $urandom_range(1, 30);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: every sample mode
    sample(MODE_DISCRETE, 32'h1234_5678);
    sample(MODE_CONTINUOUS, 32'd0);
    sample(MODE_INTERPOLATE, 32'hffff_ffff);

    // small hand-made table: zero-width bin, truncation of negatives, extremes
    write_entry(7'd0, 32'hfffe_8000, 32'd10);
    write_entry(7'd1, 32'h7fff_ffff, 32'd10);
    write_entry(7'd2, 32'h8000_0000, 32'd20);
    write_entry(7'd3, 32'h0003_4000, 32'hffff_ffff);
    write_entry(7'd4, 32'h0001_0000, 32'hdead_beef);
    write_entry(7'd100, 32'h5555_5555, 32'd0);
    set_bins(7'd4);
    sample(MODE_DISCRETE, 32'd0);
    sample(MODE_DISCRETE, 32'd10);
    sample(MODE_DISCRETE, 32'hffff_ffff);
    sample(MODE_CONTINUOUS, 32'd9);
    sample(MODE_CONTINUOUS, 32'hffff_ffff);
    sample(MODE_INTERPOLATE, 32'd5);
    sample(MODE_INTERPOLATE, 32'd10);
    sample(MODE_INTERPOLATE, 32'd15);
    sample(MODE_INTERPOLATE, 32'h8000_0000);
    set_bins(7'd3);
    sample(MODE_CONTINUOUS, 32'd21);
    sample(MODE_INTERPOLATE, 32'hffff_fff0);
    sample(MODE_DISCRETE, 32'd25);

    // random phases over several table sizes
    for (int p = 0; p < PHASES; p++) begin
      if (p % 4 == 0) load_table(p / 4);
      set_bins(bins_choice[p]);
      if (p == 2) hold_req = 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          word = $urandom_range(0, BINS);
          write_entry(word[6:0], random_value(),
                      (word < BINS) ? sb.cum_tab[word] : $urandom());
        end else if (pick < 12) begin
          write_entry(7'($urandom_range(BINS + 1, 127)), $urandom(), $urandom());
        end else begin
          sample(2'($urandom_range(1, 3)), pick_word());
        end
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending_samples.size() == 0) begin
      $display("inverse_cdf_table_sampler: match");
    end else begin
      $display("inverse_cdf_table_sampler: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/icdf_pkg.sv
sv/icdf_if.sv
sv/icdf_cell.sv
sv/icdf_div.sv
sv/inverse_cdf_table_sampler.sv
tb/inverse_cdf_table_sampler_tb.sv
